@@ rtl/core/fssm_pkg.sv @@
package fssm_pkg;

  // Widths fixed by the item fields and the register map
  localparam int DEB_W      = 10;
  localparam int RAMP_W     = 10;
  localparam int STEP_W     = 8;
  localparam int PERIOD_W   = 14;
  localparam int AUTO_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Default parameter values
  localparam int POT_BITS_DEF  = 12;
  localparam int DUTY_BITS_DEF = 8;

  // Register reset values
  localparam logic [DEB_W-1:0]    DEBOUNCE_TICKS_RST = DEB_W'(50);
  localparam logic [RAMP_W-1:0]   RAMP_INTERVAL_RST  = RAMP_W'(30);
  localparam logic [STEP_W-1:0]   RAMP_STEP_RST      = STEP_W'(5);
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = PERIOD_W'(200);

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_RAMP_INTERVAL  = 2'd1,
    REG_RAMP_STEP      = 2'd2,
    REG_SAMPLE_PERIOD  = 2'd3
  } reg_index_t;

endpackage

@@ rtl/core/fssm_scale.sv @@
// Scale a pot reading to duty range: floor(pot * DUTY_MAX / POT_MAX).
// POT_MAX is 2^POT_BITS - 1, so the division folds the high part back onto
// the low part a few times and finishes with one compare and subtract.
module fssm_scale
  import fssm_pkg::*;
#(
  parameter int POT_BITS  = POT_BITS_DEF,
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic [POT_BITS-1:0]  pot,
  output logic [DUTY_BITS-1:0] scaled
);

  localparam int XW    = POT_BITS + DUTY_BITS;
  // Three folds bring the remainder below twice the divisor while
  // DUTY_BITS stays within twice POT_BITS.
  localparam int FOLDS = 3;
  localparam logic [XW-1:0] DIVISOR = {{DUTY_BITS{1'b0}}, {POT_BITS{1'b1}}};

  logic [XW-1:0] prod;
  logic [XW-1:0] quo;
  logic [XW-1:0] rem;

  // pot * (2^DUTY_BITS - 1) as a shift and subtract
  assign prod = {pot, {DUTY_BITS{1'b0}}} - XW'(pot);

  always_comb begin
    quo = '0;
    rem = prod;
    for (int i = 0; i < FOLDS; i++) begin
      quo = quo + (rem >> POT_BITS);
      rem = (rem & DIVISOR) + (rem >> POT_BITS);
    end
    if (rem >= DIVISOR) begin
      quo = quo + XW'(1);
    end
    scaled = quo[DUTY_BITS-1:0];
  end

endmodule

@@ rtl/core/fan_soft_start_mode_controller.sv @@
// An accepted input item waits in the input register, then retires into the
// result register once that register is free or being emptied.
// Throughput: one item per cycle; a held result stalls the input only once both
// registers are full. Each item's debounce, sampling and ramp update is one pass.
// Reset (rst, synchronous, active high): registers return to 50/30/5/200,
// duty and target go to zero, automatic mode, button released, no ramp.
module fan_soft_start_mode_controller
  import fssm_pkg::*;
#(
  parameter int POT_BITS  = POT_BITS_DEF,
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: button_level, pot_sample[POT_BITS], auto_speed[8], zero pad
  input  logic [((POT_BITS + AUTO_W + 8) / 8) * 8 - 1:0] s_tdata,
  // Result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: pwm_duty[DUTY_BITS], manual_mode, ramp_busy, zero pad
  output logic [((DUTY_BITS + 9) / 8) * 8 - 1:0]         m_tdata,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IN_BITS  = 1 + POT_BITS + AUTO_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DUTY_BITS + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DEB_W-1:0]    debounce_ticks;
  logic [RAMP_W-1:0]   ramp_interval;
  logic [STEP_W-1:0]   ramp_step;
  logic [PERIOD_W-1:0] sample_period;
  logic                cfg_write;
  reg_index_t          cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_TICKS_RST;
      ramp_interval  <= RAMP_INTERVAL_RST;
      ramp_step      <= RAMP_STEP_RST;
      sample_period  <= SAMPLE_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[DEB_W-1:0];
        REG_RAMP_INTERVAL:  ramp_interval  <= pwdata[RAMP_W-1:0];
        REG_RAMP_STEP:      ramp_step      <= pwdata[STEP_W-1:0];
        REG_SAMPLE_PERIOD:  sample_period  <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_DEBOUNCE_TICKS: prdata = CFG_DATA_W'(debounce_ticks);
      REG_RAMP_INTERVAL:  prdata = CFG_DATA_W'(ramp_interval);
      REG_RAMP_STEP:      prdata = CFG_DATA_W'(ramp_step);
      REG_SAMPLE_PERIOD:  prdata = CFG_DATA_W'(sample_period);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register. The item sitting here is processed and retired into
  // the result register in the same cycle whenever that register is free
  // or being emptied, so a new item can enter every cycle.
  // ---------------------------------------------------------------------
  logic                 in_valid;
  logic                 in_button;
  logic [POT_BITS-1:0]  in_pot;
  logic [AUTO_W-1:0]    in_auto;
  logic                 advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload needs no reset; hold it until the slot is refilled
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_button <= s_tdata[0];
      in_pot    <= s_tdata[POT_BITS:1];
      in_auto   <= s_tdata[POT_BITS+AUTO_W:POT_BITS+1];
    end
  end

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  logic [DUTY_BITS-1:0] duty_now,        duty_now_next;
  logic [DUTY_BITS-1:0] target_speed,    target_speed_next;
  logic                 mode_manual,     mode_manual_next;
  logic                 button_stable,   button_stable_next;
  logic                 button_previous;
  logic [DEB_W-1:0]     debounce_count,  debounce_count_next;
  logic [RAMP_W-1:0]    ramp_count,      ramp_count_next;
  logic [PERIOD_W-1:0]  sample_count,    sample_count_next;
  logic                 ramping,         ramping_next;

  logic [DUTY_BITS-1:0] pot_scaled;

  fssm_scale #(
    .POT_BITS  (POT_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_scale (
    .pot    (in_pot),
    .scaled (pot_scaled)
  );

  // Debounce: count ticks of unchanged level, saturating. The counters
  // only need to reach the largest register value, so they saturate at
  // all ones of the register width.
  logic stable_hit;

  always_comb begin
    if (in_button != button_previous) begin
      debounce_count_next = '0;
    end else if (debounce_count == '1) begin
      debounce_count_next = debounce_count;
    end else begin
      debounce_count_next = debounce_count + DEB_W'(1);
    end
    stable_hit = (debounce_count_next >= debounce_ticks) && (in_button != button_stable);
    // Toggle mode on a stable released-to-pressed edge
    mode_manual_next   = mode_manual ^ (stable_hit && button_stable && !in_button);
    button_stable_next = stable_hit ? in_button : button_stable;
  end

  // Sample and ramp timing
  logic                 do_step;
  logic [RAMP_W-1:0]    ramp_inc;
  logic [PERIOD_W-1:0]  sample_inc;

  always_comb begin
    ramp_inc   = (ramp_count == '1) ? ramp_count : ramp_count + RAMP_W'(1);
    sample_inc = (sample_count == '1) ? sample_count : sample_count + PERIOD_W'(1);

    ramp_count_next   = ramp_count;
    sample_count_next = sample_count;
    target_speed_next = target_speed;
    do_step           = 1'b0;

    if (ramping) begin
      // Keep ramping to the old target even if the mode changed
      if (ramp_inc >= ramp_interval) begin
        ramp_count_next = '0;
        do_step         = 1'b1;
      end else begin
        ramp_count_next = ramp_inc;
      end
    end else begin
      if (sample_inc >= sample_period) begin
        sample_count_next = '0;
        // Sample with this tick's mode; step at once toward the new target
        target_speed_next = mode_manual_next ? pot_scaled : DUTY_BITS'(in_auto);
        ramp_count_next   = '0;
        do_step           = 1'b1;
      end else begin
        sample_count_next = sample_inc;
      end
    end
  end

  // One duty step toward the target, clamped there; a zero step acts as one
  logic [DUTY_BITS-1:0] step_size;
  logic [DUTY_BITS:0]   step_sum;
  logic [DUTY_BITS-1:0] step_gap;
  logic [DUTY_BITS-1:0] stepped;

  always_comb begin
    step_size = (ramp_step == '0) ? DUTY_BITS'(1) : DUTY_BITS'(ramp_step);
    step_sum  = {1'b0, duty_now} + {1'b0, step_size};
    step_gap  = duty_now - target_speed_next;
    if (target_speed_next > duty_now) begin
      stepped = (step_sum > {1'b0, target_speed_next}) ? target_speed_next
                                                        : step_sum[DUTY_BITS-1:0];
    end else if (target_speed_next < duty_now) begin
      stepped = (step_size >= step_gap) ? target_speed_next : duty_now - step_size;
    end else begin
      stepped = duty_now;
    end
    duty_now_next = do_step ? stepped : duty_now;
    ramping_next  = do_step ? (stepped != target_speed_next) : ramping;
  end

  // Commit state only when the item retires into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_now        <= '0;
      target_speed    <= '0;
      mode_manual     <= 1'b0;
      button_stable   <= 1'b1;
      button_previous <= 1'b1;
      debounce_count  <= '0;
      ramp_count      <= '0;
      sample_count    <= '0;
      ramping         <= 1'b0;
    end else if (advance) begin
      duty_now        <= duty_now_next;
      target_speed    <= target_speed_next;
      mode_manual     <= mode_manual_next;
      button_stable   <= button_stable_next;
      button_previous <= in_button;
      debounce_count  <= debounce_count_next;
      ramp_count      <= ramp_count_next;
      sample_count    <= sample_count_next;
      ramping         <= ramping_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [DUTY_BITS-1:0] res_duty;
  logic                 res_manual;
  logic                 res_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_duty   <= duty_now_next;
      res_manual <= mode_manual_next;
      res_busy   <= ramping_next;
    end
  end

  assign m_tdata = OUT_W'({res_busy, res_manual, res_duty});

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The ramp flag always tracks whether duty has reached the target
  a_ramp_flag: assert property (@(posedge clk) disable iff (rst)
    ramping == (duty_now != target_speed))
    else $error("ramping flag disagrees with duty and target");

  // State moves only when an item retires
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(duty_now) && $stable(mode_manual) && $stable(target_speed))
    else $error("controller state changed without an item");

  // A retiring item always leaves a result behind
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("retired item produced no result");

  // The result carries the committed state
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res_duty == duty_now) && (res_manual == mode_manual)
                && (res_busy == ramping))
    else $error("result register differs from committed state");

endmodule

@@ bench/tb_fan_soft_start_mode_controller.sv @@
import fssm_pkg::*;

class fan_ramp_scoreboard;

  typedef struct packed {
    logic [7:0] duty;
    logic       manual;
    logic       busy;
  } duty_report_t;

  // register copies
  logic [DEB_W-1:0]    deb_ticks;
  logic [RAMP_W-1:0]   ramp_ivl;
  logic [STEP_W-1:0]   step_size;
  logic [PERIOD_W-1:0] period;

  // controller state
  logic [7:0]  duty;
  logic [7:0]  target;
  logic        manual;
  logic        btn_stable;
  logic        btn_prev;
  logic [15:0] deb_cnt;
  logic [15:0] ramp_cnt;
  logic [15:0] smp_cnt;
  logic        ramping;

  duty_report_t expected_reports[$];
  int errors;
  int ticks;
  int reports;
  int toggles;
  int duty_steps;

  function new();
    deb_ticks  = DEBOUNCE_TICKS_RST;
    ramp_ivl   = RAMP_INTERVAL_RST;
    step_size  = RAMP_STEP_RST;
    period     = SAMPLE_PERIOD_RST;
    duty       = '0;
    target     = '0;
    manual     = 1'b0;
    btn_stable = 1'b1;
    btn_prev   = 1'b1;
    deb_cnt    = '0;
    ramp_cnt   = '0;
    smp_cnt    = '0;
    ramping    = 1'b0;
    errors     = 0;
    ticks      = 0;
    reports    = 0;
    toggles    = 0;
    duty_steps = 0;
  endfunction

  function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_DEBOUNCE_TICKS: deb_ticks = v[DEB_W-1:0];
      REG_RAMP_INTERVAL:  ramp_ivl  = v[RAMP_W-1:0];
      REG_RAMP_STEP:      step_size = v[STEP_W-1:0];
      REG_SAMPLE_PERIOD:  period    = v[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] sat_inc(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  // move the duty one step toward the target, clamped at the target
  function void step_duty();
    logic [8:0] s;
    logic [8:0] n;
    logic [8:0] gap;
    s = (step_size == '0) ? 9'd1 : {1'b0, step_size};
    if (target > duty) begin
      n = {1'b0, duty} + s;
      duty = (n > {1'b0, target}) ? target : n[7:0];
    end else if (target < duty) begin
      gap = {1'b0, duty} - {1'b0, target};
      duty = (s >= gap) ? target : duty - s[7:0];
    end
    ramping = (duty != target);
    duty_steps++;
  endfunction

  function void note_tick(logic btn, logic [11:0] pot, logic [7:0] aut);
    duty_report_t r;
    ticks++;
    if (btn != btn_prev) deb_cnt = '0;
    else deb_cnt = sat_inc(deb_cnt);
    if (deb_cnt >= {6'd0, deb_ticks} && btn != btn_stable) begin
      if (btn_stable && !btn) begin
        manual = ~manual;
        toggles++;
      end
      btn_stable = btn;
    end
    btn_prev = btn;

    if (ramping) begin
      ramp_cnt = sat_inc(ramp_cnt);
      if (ramp_cnt >= {6'd0, ramp_ivl}) begin
        ramp_cnt = '0;
        step_duty();
      end
    end else begin
      smp_cnt = sat_inc(smp_cnt);
      if (smp_cnt >= {2'd0, period}) begin
        smp_cnt = '0;
        if (manual) target = 8'((int'(pot) * 255) / 4095);
        else target = aut;
        ramp_cnt = '0;
        step_duty();
      end
    end

    r.duty   = duty;
    r.manual = manual;
    r.busy   = ramping;
    expected_reports.push_back(r);
  endfunction

  function void check_report(logic [7:0] d, logic m, logic b);
    duty_report_t e;
    if (expected_reports.size() == 0) begin
      $error("result item with nothing expected: duty %0d manual %0b busy %0b", d, m, b);
      errors++;
      return;
    end
    e = expected_reports.pop_front();
    reports++;
    if (d !== e.duty) begin
      $error("pwm_duty: expected %0d, actual %0d", e.duty, d);
      errors++;
    end
    if (m !== e.manual) begin
      $error("manual_mode: expected %0b, actual %0b", e.manual, m);
      errors++;
    end
    if (b !== e.busy) begin
      $error("ramp_busy: expected %0b, actual %0b", e.busy, b);
      errors++;
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

endclass

module tb_fan_soft_start_mode_controller;

  // button, pot[12], auto[8] -> 21 bits, padded to 24
  localparam int IN_W  = 24;
  // duty[8], manual, busy -> 10 bits, padded to 16
  localparam int OUT_W = 16;

  logic clk = 1'b0;
  logic rst;

  logic                  s_tvalid;
  logic                  s_tready;
  // tdata: button_level, pot_sample[12], auto_speed[8], zero pad
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // tdata: pwm_duty[8], manual_mode, ramp_busy, zero pad
  logic [OUT_W-1:0]      m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fan_ramp_scoreboard sb;

  // Shared flags between the sender and the receiver process
  bit quiet;          // no idling on either side
  bit long_hold_req;  // ask the receiver for one long hold-off

  // Sender-side view of the current debounce setting, for shaping presses
  int cur_deb;

  fan_soft_start_mode_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  // Note every accepted tick; values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_tick(s_tdata[0], s_tdata[12:1], s_tdata[20:13]);
  end

  // Compare every accepted result item against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_report(m_tdata[7:0], m_tdata[8], m_tdata[9]);
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one tick and hold it until accepted; maybe drop valid for a burst afterwards
  task automatic send_tick(logic btn, logic [11:0] pot, logic [7:0] aut);
    s_tdata  <= {3'b000, aut, pot, btn};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come or the limit
  // runs out, then let the pipeline settle
  task automatic drain(int limit);
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; upper bits beyond the register width are random
  task automatic write_reg(reg_index_t idx, int unsigned value, int w);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] v;
    mask = (32'h1 << w) - 32'h1;
    v = ($urandom() & ~mask) | (value & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    if (idx == REG_DEBOUNCE_TICKS) cur_deb = value & mask;
  endtask

  task automatic configure(int deb, int ivl, int stp, int per);
    write_reg(REG_DEBOUNCE_TICKS, deb, DEB_W);
    write_reg(REG_RAMP_INTERVAL, ivl, RAMP_W);
    write_reg(REG_RAMP_STEP, stp, STEP_W);
    write_reg(REG_SAMPLE_PERIOD, per, PERIOD_W);
  endtask

  function automatic logic [11:0] pick_pot();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'd4095;
      default: return 12'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_auto();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom());
    endcase
  endfunction

  // Random ticks: with a debounce setting up to 40, the button mostly makes clean presses and
  // releases that outlast the debounce window, with some short glitches; above 40 all runs are short
  task automatic random_ticks(int count, bit with_hold);
    logic btn;
    int   run_left;
    btn = 1'b1;
    run_left = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 5) long_hold_req = 1'b1;
      if (run_left == 0) begin
        btn = ~btn;
        if (cur_deb > 40)
          run_left = $urandom_range(1, 30);
        else if (cur_deb > 0 && $urandom_range(0, 4) == 0)
          run_left = $urandom_range(1, cur_deb);
        else
          run_left = $urandom_range(cur_deb + 1, cur_deb + 6);
      end
      run_left--;
      send_tick(btn, pick_pot(), pick_auto());
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    long_hold_req = 1'b0;
    cur_deb = 50;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero settings: instant debounce, interval, period and step all act as 1
    configure(0, 0, 0, 0);
    send_tick(1'b1, 12'd0, 8'd255);
    send_tick(1'b1, 12'd4095, 8'd255);
    send_tick(1'b1, 12'd4095, 8'd0);
    // press: toggle into manual mode while a ramp is in flight
    send_tick(1'b0, 12'd4095, 8'd0);
    send_tick(1'b0, 12'd4095, 8'd0);
    send_tick(1'b1, 12'd4095, 8'd255);
    send_tick(1'b1, 12'd0, 8'd255);
    send_tick(1'b0, 12'd2048, 8'd128);
    send_tick(1'b1, 12'd1, 8'd1);
    drain(2000);

    // Full step and fastest ramp: jump straight to each target
    configure(1, 1, 255, 1);
    send_tick(1'b1, 12'd4095, 8'd255);
    send_tick(1'b0, 12'd4095, 8'd255);
    send_tick(1'b0, 12'd4095, 8'd0);
    send_tick(1'b0, 12'd0, 8'd0);
    send_tick(1'b1, 12'd0, 8'd255);
    send_tick(1'b1, 12'd4095, 8'd0);
    send_tick(1'b0, 12'd4094, 8'd254);
    send_tick(1'b0, 12'd16, 8'd1);
    send_tick(1'b1, 12'd4095, 8'd0);
    send_tick(1'b1, 12'd0, 8'd255);
    drain(2000);

    // Random phases, each under its own settings; drained before every write
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      configure(($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 6),
                ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 5),
                ($urandom_range(0, 3) == 0) ? 255  : $urandom_range(0, 40),
                ($urandom_range(0, 9) == 0) ? 16383 : $urandom_range(0, 12));
      random_ticks(45, ph == 5);
      drain(5000);
    end

    // Widest settings: long windows, so only the counters move
    configure(1023, 1023, 1, 16383);
    for (int i = 0; i < 12; i++)
      send_tick(1'b0, 12'($urandom()), 8'($urandom()));
    drain(5000);
    configure(0, 1, 7, 1);
    random_ticks(30, 1'b0);
    drain(5000);
    repeat (10) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected result items never arrived", sb.pending());
      sb.errors++;
    end
    $display("Covered %0d ticks and %0d checked results under varied register settings,",
             sb.ticks, sb.reports);
    $display("with %0d mode toggles and %0d duty steps.", sb.toggles, sb.duty_steps);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fssm_pkg.sv
rtl/core/fssm_scale.sv
rtl/core/fan_soft_start_mode_controller.sv
bench/tb_fan_soft_start_mode_controller.sv
